@@ design/apq_pkg.sv @@
// ============================================================================
// apq_pkg
// Shared types and codes for the array priority queue: result status codes,
// controller states, and the command/status bundles between the controller
// and the datapath.
// ============================================================================
`default_nettype none

package apq_pkg;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SCAN_END,
    S_SHIFT_INIT,
    S_SHIFT,
    S_DONE
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;     // latch an accepted request
    logic decide;      // resolve insert / drop / empty, or arm the scan
    logic scan_rd;     // read the next entry for the max search
    logic shift_init;  // point the shift pointer past the winner
    logic shift_rd;    // read the next entry to move down one slot
    logic commit;      // finish a remove: drop one entry, post the winner
    logic load_out;    // move the result into the output register
  } apq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic req_remove;  // latched request is a remove
    logic empty;       // no entries held
    logic scan_last;   // the scan read now issued is the last held entry
    logic shift_done;  // no entries left to move
    logic out_busy;    // output register holds a result not yet taken
  } apq_stat_t;

endpackage : apq_pkg

`default_nettype wire

@@ design/apq_if.sv @@
// ============================================================================
// apq_req_if / apq_rsp_if
// Valid/ready channels of the array priority queue: the request channel
// carries insert and remove requests, the response channel one result each.
// ============================================================================
`default_nettype none

interface apq_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] client_id;
  logic [7:0]  prio;

  modport source (output valid, input ready, output req_type, output client_id,
                  output prio);
  modport sink   (input valid, output ready, input req_type, input client_id,
                  input prio);
endinterface : apq_req_if

interface apq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_client_id;
  logic [7:0]  out_prio;
  logic [7:0]  occupancy;

  modport source (output valid, input ready, output status, output out_client_id,
                  output out_prio, output occupancy);
  modport sink   (input valid, output ready, input status, input out_client_id,
                  input out_prio, input occupancy);
endinterface : apq_rsp_if

`default_nettype wire

@@ design/apq_ctrl.sv @@
// ============================================================================
// apq_ctrl
// Sequencer of the array priority queue: takes one request at a time, walks
// the datapath through the max scan and the gap-closing shift, and hands the
// result to the output register.
// ============================================================================
`default_nettype none

module apq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire apq_pkg::apq_stat_t stat,
  output apq_pkg::apq_cmd_t      cmd
);
  import apq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.req_remove && !stat.empty) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      // last compare lands this cycle
      S_SCAN_END: begin
        state_next = S_SHIFT_INIT;
      end
      S_SHIFT_INIT: begin
        cmd.shift_init = 1'b1;
        state_next     = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.commit = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.shift_rd = 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule : apq_ctrl

`default_nettype wire

@@ design/apq_dp.sv @@
// ============================================================================
// apq_dp
// Datapath of the array priority queue: entry store, fill count, scan and
// shift pointers, running maximum and the output register.
// ============================================================================
`default_nettype none

module apq_dp #(
  parameter int DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire apq_pkg::apq_cmd_t  cmd,
  output apq_pkg::apq_stat_t      stat,
  input  wire logic               in_req_type,
  input  wire logic [15:0]        in_client_id,
  input  wire logic [7:0]         in_prio,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic [15:0]             out_client_id,
  output logic [7:0]              out_prio,
  output logic [7:0]              out_occupancy
);
  import apq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Entry store: {client_id, prio}
  logic [23:0]   mem [0:DEPTH-1];
  logic [23:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [23:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  // Request and search state
  logic          req_type;
  logic [15:0]   req_id;
  logic [7:0]    req_prio;
  logic [CW-1:0] fill;
  logic [CW-1:0] idx;
  logic [CW-1:0] shift_ptr;
  logic          rd_scan;
  logic          rd_shift;
  logic [AW-1:0] rd_pos;
  logic [AW-1:0] best_pos;
  logic [15:0]   best_id;
  logic [7:0]    best_prio;
  logic          better;
  status_t       res_status;
  logic [15:0]   res_id;
  logic [7:0]    res_prio;
  logic          full;

  assign full = (fill == CW'(DEPTH));

  // Status to controller
  assign stat.req_remove = (req_type == REQ_REMOVE);
  assign stat.empty      = (fill == '0);
  assign stat.scan_last  = (idx == fill - CW'(1));
  assign stat.shift_done = (shift_ptr >= fill);
  assign stat.out_busy   = out_valid && !out_ready;

  // Memory port selection
  assign mem_re    = cmd.scan_rd || cmd.shift_rd;
  assign mem_raddr = cmd.scan_rd ? idx[AW-1:0] : shift_ptr[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill[AW-1:0];
    mem_wdata = {req_id, req_prio};
    if (cmd.decide && req_type == REQ_INSERT && !full) begin
      mem_we = 1'b1;
    end else if (rd_shift) begin
      // move the entry just read down one slot
      mem_we    = 1'b1;
      mem_waddr = rd_pos - AW'(1);
      mem_wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Candidate beats the running best: higher prio, then smaller id
  assign better = (rd_pos == '0) || (rdata[7:0] > best_prio) ||
                  ((rdata[7:0] == best_prio) && (rdata[23:8] < best_id));

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rd_scan   <= 1'b0;
      rd_shift  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_scan  <= cmd.scan_rd;
      rd_shift <= cmd.shift_rd;
      if (cmd.decide && req_type == REQ_INSERT && !full) begin
        fill <= fill + CW'(1);
      end else if (cmd.commit) begin
        fill <= fill - CW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type <= in_req_type;
      req_id   <= in_client_id;
      req_prio <= in_prio;
    end

    // Resolve the simple outcomes and arm the scan
    if (cmd.decide) begin
      res_id   <= '0;
      res_prio <= '0;
      idx      <= '0;
      if (req_type == REQ_INSERT) begin
        res_status <= full ? ST_DROPPED : ST_INSERTED;
      end else begin
        res_status <= ST_EMPTY;
      end
    end

    if (cmd.scan_rd) begin
      idx <= idx + CW'(1);
    end
    if (mem_re) begin
      rd_pos <= mem_raddr;
    end

    // Track the running maximum
    if (rd_scan && better) begin
      best_pos  <= rd_pos;
      best_id   <= rdata[23:8];
      best_prio <= rdata[7:0];
    end

    if (cmd.shift_init) begin
      shift_ptr <= CW'(best_pos) + CW'(1);
    end else if (cmd.shift_rd) begin
      shift_ptr <= shift_ptr + CW'(1);
    end

    if (cmd.commit) begin
      res_status <= ST_REMOVED;
      res_id     <= best_id;
      res_prio   <= best_prio;
    end

    if (cmd.load_out) begin
      out_status    <= res_status;
      out_client_id <= res_id;
      out_prio      <= res_prio;
      out_occupancy <= 8'(fill);
    end
  end

endmodule : apq_dp

`default_nettype wire

@@ design/array_priority_queue_top.sv @@
// ============================================================================
// array_priority_queue_top
// Max-priority queue over an unsorted array of DEPTH entries.
// ============================================================================
// Usage:
//   req (sink): req_type 0 inserts {client_id, prio} after the last entry,
//   req_type 1 removes the entry with the largest prio (ties: smaller
//   client_id, then earlier position). Each request gives one response on
//   rsp (source): status, removed id/prio (zero unless removed), occupancy.
//   Requests are taken one at a time; req.ready is high only while idle.
//   An insert, a drop or an empty remove makes no pass over the entry
//   store. A remove over N held entries makes two passes through its
//   single read port: one pass reads all N entries for the max, a second
//   pass reads and rewrites the entries after the winner to close the gap.
//   The next request is taken the cycle after the response is loaded.
//   The result sits in an output register; while rsp is stalled it holds
//   and the next request waits at its last step until the register frees.
//   Reset (synchronous, active high) empties the queue and drops any
//   pending response; no clearing pass is needed.
// ============================================================================
`default_nettype none

module array_priority_queue_top #(
  parameter int DEPTH = 128
) (
  input  wire logic  clk,
  input  wire logic  rst,
  apq_req_if.sink    req,
  apq_rsp_if.source  rsp
);
  import apq_pkg::*;

  apq_cmd_t  cmd;
  apq_stat_t stat;

  apq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  apq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_type   (req.req_type),
    .in_client_id  (req.client_id),
    .in_prio       (req.prio),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_status    (rsp.status),
    .out_client_id (rsp.out_client_id),
    .out_prio      (rsp.out_prio),
    .out_occupancy (rsp.occupancy)
  );

endmodule : array_priority_queue_top

`default_nettype wire

@@ design/apq_checker.sv @@
// ============================================================================
// apq_port_checker
// Port-level checks of the array priority queue, bound to the top level.
// ============================================================================
`default_nettype none

module apq_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  status,
  input wire logic [15:0] out_client_id,
  input wire logic [7:0]  out_prio,
  input wire logic [7:0]  occupancy
);
  import apq_pkg::*;

  // Reset drops any pending response
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // One request in flight: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another is in flight");

  // Only a remove carries a client id and priority
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_REMOVED) |-> (out_client_id == '0 && out_prio == '0))
    else $error("nonzero payload on a non-remove response");

  // An empty report means nothing is held
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_EMPTY) |-> (occupancy == '0))
    else $error("empty status with nonzero occupancy");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) &&
    $stable(out_client_id) && $stable(out_prio) && $stable(occupancy)))
    else $error("stalled response changed");

endmodule : apq_port_checker

bind array_priority_queue_top apq_port_checker u_apq_port_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .out_client_id (rsp.out_client_id),
  .out_prio      (rsp.out_prio),
  .occupancy     (rsp.occupancy)
);

`default_nettype wire
